@@ hw/rtl/latency_stats_top_k_tracker_unit_assert.svh @@
// Assertion macros for the latency statistics unit
`ifndef LATENCY_STATS_TOP_K_TRACKER_UNIT_ASSERT_SVH
`define LATENCY_STATS_TOP_K_TRACKER_UNIT_ASSERT_SVH

// implication in the same cycle
`define LSTK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication on the following cycle
`define LSTK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lstk_pkg.sv @@
`timescale 1ns / 1ps

package lstk_pkg;

    localparam int NUM_CLASSES = 6;
    localparam int KEEP        = 8;

    localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int KIDX_W = (KEEP > 1) ? $clog2(KEEP) : 1;
    localparam int KCNT_W = 7;

    localparam logic [31:0] THRESHOLD_RESET = 32'd100000;

    localparam logic [1:0] CMD_RECORD     = 2'd0;
    localparam logic [1:0] CMD_READ_CLASS = 2'd1;
    localparam logic [1:0] CMD_READ_ENTRY = 2'd2;
    localparam logic [1:0] CMD_CLEAR      = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_CLASS = 2'd1;
    localparam logic [1:0] STAT_NO_ENTRY  = 2'd2;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] MAX32 = 48'h0000_FFFF_FFFF;

    typedef logic [42:0] tag_t;

endpackage

@@ hw/rtl/latency_stats_top_k_tracker_unit.sv @@
// One item at a time: s_tready is high only in idle, so a new item is taken once the last
//   result has loaded; that waits while an untaken result is held. Reads and clears go
//   straight to the result; an event runs count, total, max, measured total and slow check,
//   and a slow one is placed by the shared comparator walking the kept list, or dropped.
// Reset (aresetn low, synchronous): statistics and list length cleared,
//   threshold back to 100000 us, no result pending.
`timescale 1ns / 1ps

module latency_stats_top_k_tracker_unit
    import lstk_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op_class, conn_state, client_id, duration, entry_index
    input  logic [87:0]  s_tdata,
    // cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // class_count, class_total, class_max, slow_total, kept_count, measured_total,
    // entry_class, entry_state, entry_client, entry_duration, rank_taken
    output logic [287:0] m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    `include "latency_stats_top_k_tracker_unit_assert.svh"

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CNT   = 4'd1;
    localparam logic [3:0] ST_TOT   = 4'd2;
    localparam logic [3:0] ST_MAX   = 4'd3;
    localparam logic [3:0] ST_MEAS  = 4'd4;
    localparam logic [3:0] ST_SLOW  = 4'd5;
    localparam logic [3:0] ST_SCAN  = 4'd6;
    localparam logic [3:0] ST_SHIFT = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [31:0]       thr_reg, thr_next;
    logic              m_valid_reg, m_valid_next;
    logic [287:0]      m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;

    logic [31:0]       cnt_reg [NUM_CLASSES];
    logic [31:0]       cnt_next [NUM_CLASSES];
    logic [47:0]       tot_reg [NUM_CLASSES];
    logic [47:0]       tot_next [NUM_CLASSES];
    logic [31:0]       max_reg [NUM_CLASSES];
    logic [31:0]       max_next [NUM_CLASSES];
    logic [47:0]       meas_reg, meas_next;
    logic [31:0]       slow_reg, slow_next;
    logic [KCNT_W-1:0] kept_reg, kept_next;

    logic [31:0]       kdur_reg [KEEP];
    logic [31:0]       kdur_next [KEEP];
    tag_t              ktag_reg [KEEP];
    tag_t              ktag_next [KEEP];

    logic [1:0]        cmd_reg, cmd_next;
    logic [2:0]        cls_reg, cls_next;
    logic [7:0]        cst_reg, cst_next;
    logic [31:0]       cli_reg, cli_next;
    logic [31:0]       dur_reg, dur_next;
    logic [KCNT_W-1:0] pos_reg, pos_next;
    logic [KCNT_W-1:0] rank_reg, rank_next;
    logic [1:0]        stat_reg, stat_next;

    logic [CIDX_W-1:0] cidx;
    logic [KIDX_W-1:0] kidx;
    logic [31:0]       rd_dur;
    tag_t              rd_tag;
    logic [KCNT_W-1:0] last_idx;

    logic [47:0]       add_a, add_b, add_res;
    logic              add_w48;
    logic [48:0]       add_sum;
    logic [31:0]       cmp_a, cmp_b;
    logic              cmp_ge;

    logic [2:0]        in_cls;
    logic [5:0]        in_idx;
    logic              show_class, show_entry;
    logic [31:0]       o_cnt, o_max, o_eclient, o_edur;
    logic [47:0]       o_tot;
    logic [2:0]        o_ecls;
    logic [7:0]        o_est;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign cfg_ready = 1'b1;

    assign in_cls = s_tdata[2:0];
    assign in_idx = s_tdata[80:75];

    assign cidx     = cls_reg[CIDX_W-1:0];
    assign kidx     = pos_reg[KIDX_W-1:0];
    assign rd_dur   = kdur_reg[kidx];
    assign rd_tag   = ktag_reg[kidx];
    assign last_idx = (kept_reg < KCNT_W'(KEEP)) ? kept_reg : KCNT_W'(KEEP - 1);

    // shared saturating adder and comparator
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_w48 = 1'b0;
        cmp_a   = '0;
        cmp_b   = '0;
        case (state_reg)
            ST_CNT: begin
                add_a = {16'b0, cnt_reg[cidx]};
                add_b = 48'd1;
            end
            ST_TOT: begin
                add_a   = tot_reg[cidx];
                add_b   = {16'b0, dur_reg};
                add_w48 = 1'b1;
            end
            ST_MAX: begin
                cmp_a = max_reg[cidx];
                cmp_b = dur_reg;
            end
            ST_MEAS: begin
                add_a   = meas_reg;
                add_b   = {16'b0, dur_reg};
                add_w48 = 1'b1;
            end
            ST_SLOW: begin
                add_a = {16'b0, slow_reg};
                add_b = 48'd1;
                cmp_a = dur_reg;
                cmp_b = thr_reg;
            end
            ST_SCAN: begin
                cmp_a = rd_dur;
                cmp_b = dur_reg;
            end
            default: begin
                add_a = '0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b};
    assign add_res = add_w48 ? (add_sum[48] ? MAX48 : add_sum[47:0])
                             : ((add_sum[48:32] != 17'd0) ? MAX32 : add_sum[47:0]);
    assign cmp_ge  = (cmp_a >= cmp_b);

    // result fields
    assign show_class = ((cmd_reg == CMD_RECORD) || (cmd_reg == CMD_READ_CLASS))
                        && (stat_reg == STAT_OK);
    assign show_entry = (cmd_reg == CMD_READ_ENTRY) && (stat_reg == STAT_OK);
    assign o_cnt      = show_class ? cnt_reg[cidx] : 32'd0;
    assign o_tot      = show_class ? tot_reg[cidx] : 48'd0;
    assign o_max      = show_class ? max_reg[cidx] : 32'd0;
    assign o_ecls     = show_entry ? rd_tag[42:40] : 3'd0;
    assign o_est      = show_entry ? rd_tag[39:32] : 8'd0;
    assign o_eclient  = show_entry ? rd_tag[31:0]  : 32'd0;
    assign o_edur     = show_entry ? rd_dur        : 32'd0;

    always_comb begin
        state_next   = state_reg;
        thr_next     = thr_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        cnt_next     = cnt_reg;
        tot_next     = tot_reg;
        max_next     = max_reg;
        meas_next    = meas_reg;
        slow_next    = slow_reg;
        kept_next    = kept_reg;
        kdur_next    = kdur_reg;
        ktag_next    = ktag_reg;
        cmd_next     = cmd_reg;
        cls_next     = cls_reg;
        cst_next     = cst_reg;
        cli_next     = cli_reg;
        dur_next     = dur_reg;
        pos_next     = pos_reg;
        rank_next    = rank_reg;
        stat_next    = stat_reg;

        if (cfg_valid) begin
            thr_next = cfg_data;
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = s_tuser;
                    cls_next  = in_cls;
                    cst_next  = s_tdata[10:3];
                    cli_next  = s_tdata[42:11];
                    dur_next  = s_tdata[74:43];
                    pos_next  = {1'b0, in_idx};
                    rank_next = KCNT_W'(KEEP);
                    stat_next = STAT_OK;
                    state_next = ST_OUT;
                    case (s_tuser)
                        CMD_RECORD, CMD_READ_CLASS: begin
                            if ({1'b0, in_cls} >= 4'(NUM_CLASSES)) begin
                                stat_next = STAT_BAD_CLASS;
                            end else if (s_tuser == CMD_RECORD) begin
                                state_next = ST_CNT;
                            end
                        end
                        CMD_READ_ENTRY: begin
                            if (({1'b0, in_idx} >= kept_reg)
                                    || ({1'b0, in_idx} >= KCNT_W'(KEEP))) begin
                                stat_next = STAT_NO_ENTRY;
                            end
                        end
                        default: begin
                            for (int i = 0; i < NUM_CLASSES; i++) begin
                                cnt_next[i] = '0;
                                tot_next[i] = '0;
                                max_next[i] = '0;
                            end
                            meas_next = '0;
                            slow_next = '0;
                            kept_next = '0;
                        end
                    endcase
                end
            end
            ST_CNT: begin
                cnt_next[cidx] = add_res[31:0];
                state_next     = ST_TOT;
            end
            ST_TOT: begin
                tot_next[cidx] = add_res;
                state_next     = ST_MAX;
            end
            ST_MAX: begin
                if (!cmp_ge) begin
                    max_next[cidx] = dur_reg;
                end
                state_next = ST_MEAS;
            end
            ST_MEAS: begin
                meas_next  = add_res;
                state_next = ST_SLOW;
            end
            ST_SLOW: begin
                if (cmp_ge) begin
                    slow_next  = add_res[31:0];
                    pos_next   = '0;
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SCAN: begin
                if ((pos_reg < kept_reg) && cmp_ge) begin
                    pos_next = pos_reg + KCNT_W'(1);
                end else if (pos_reg >= KCNT_W'(KEEP)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                for (int i = 0; i < KEEP; i++) begin
                    if (KCNT_W'(i) == pos_reg) begin
                        kdur_next[i] = dur_reg;
                        ktag_next[i] = {cls_reg, cst_reg, cli_reg};
                    end else if ((i > 0) && (KCNT_W'(i) > pos_reg)
                                 && (KCNT_W'(i) <= last_idx)) begin
                        kdur_next[i] = kdur_reg[(i > 0) ? i - 1 : 0];
                        ktag_next[i] = ktag_reg[(i > 0) ? i - 1 : 0];
                    end
                end
                if (kept_reg < KCNT_W'(KEEP)) begin
                    kept_next = kept_reg + KCNT_W'(1);
                end
                rank_next  = pos_reg;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = stat_reg;
                    m_data_next  = {7'd0, rank_reg, o_edur, o_eclient, o_est, o_ecls,
                                    meas_reg, kept_reg, slow_reg, o_max, o_tot, o_cnt};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= THRESHOLD_RESET;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                cnt_reg[i] <= '0;
                tot_reg[i] <= '0;
                max_reg[i] <= '0;
            end
            meas_reg <= '0;
            slow_reg <= '0;
            kept_reg <= '0;
        end else begin
            state_reg   <= state_next;
            thr_reg     <= thr_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            tot_reg     <= tot_next;
            max_reg     <= max_next;
            meas_reg    <= meas_next;
            slow_reg    <= slow_next;
            kept_reg    <= kept_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        kdur_reg   <= kdur_next;
        ktag_reg   <= ktag_next;
        cmd_reg    <= cmd_next;
        cls_reg    <= cls_next;
        cst_reg    <= cst_next;
        cli_reg    <= cli_next;
        dur_reg    <= dur_next;
        pos_reg    <= pos_next;
        rank_reg   <= rank_next;
        stat_reg   <= stat_next;
    end

    `LSTK_ASSERT_NOW(a_kept_bound, 1'b1, kept_reg <= KCNT_W'(KEEP),
        "kept list longer than its capacity")
    `LSTK_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg != ST_IDLE,
        "accepted item did not start work")
    `LSTK_ASSERT_NOW(a_scan_bound, state_reg == ST_SCAN, pos_reg <= kept_reg,
        "walk position beyond filled entries")
    `LSTK_ASSERT_NOW(a_shift_bound, state_reg == ST_SHIFT, pos_reg < KCNT_W'(KEEP),
        "insertion rank outside the list")

endmodule

@@ dv/latency_stats_top_k_tracker_unit_tb.sv @@
`timescale 1ns / 1ps

module latency_stats_top_k_tracker_unit_tb
    import lstk_pkg::*;
;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  op_class;
        logic [7:0]  conn_state;
        logic [31:0] client_id;
        logic [31:0] duration;
        logic [5:0]  entry_index;
    } event_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] class_count;
        logic [47:0] class_total;
        logic [31:0] class_max;
        logic [31:0] slow_total;
        logic [6:0]  kept_count;
        logic [47:0] measured_total;
        logic [2:0]  entry_class;
        logic [7:0]  entry_state;
        logic [31:0] entry_client;
        logic [31:0] entry_duration;
        logic [6:0]  rank_taken;
    } stats_result_t;

    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 30;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [87:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [287:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;

    // cfg_data writes the only register: slow_threshold_us
    latency_stats_top_k_tracker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // tracker state as the testbench sees it
    logic [31:0] thresh_m;
    logic [31:0] cls_count_m [NUM_CLASSES];
    logic [47:0] cls_total_m [NUM_CLASSES];
    logic [31:0] cls_max_m   [NUM_CLASSES];
    logic [47:0] measured_m;
    logic [31:0] slow_m;
    int          kept_n_m;
    logic [31:0] kept_dur_m [KEEP];
    tag_t        kept_tag_m [KEEP];

    event_item_t   event_queue [$];
    stats_result_t pending_results [$];
    logic [31:0]   dur_pool [$];
    logic [31:0]   gen_thresh;

    int queued_n = 0;
    int accepted_n = 0;
    int results_n = 0;
    int err_n = 0;
    int idle_cycles = 0;

    logic        s_took = 1'b0;
    int          tx_gap = 0;
    logic        tx_burst = 1'b0;
    event_item_t tx_item;

    int   rx_wait = 0;
    int   rx_hold = 0;
    logic rx_burst = 1'b0;
    logic held_off = 1'b0;

    event_item_t   seen_item;
    stats_result_t want;
    stats_result_t got;

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? MAX48 : s[47:0];
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] a);
        return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
    endfunction

    function automatic void clear_stats();
        for (int c = 0; c < NUM_CLASSES; c++) begin
            cls_count_m[c] = '0;
            cls_total_m[c] = '0;
            cls_max_m[c]   = '0;
        end
        for (int k = 0; k < KEEP; k++) begin
            kept_dur_m[k] = '0;
            kept_tag_m[k] = '0;
        end
        measured_m = '0;
        slow_m     = '0;
        kept_n_m   = 0;
    endfunction

    function automatic stats_result_t apply_command(input event_item_t it);
        stats_result_t r;
        int            pos;
        int            i;
        logic          show;
        r = '0;
        r.status = STAT_OK;
        r.rank_taken = 7'(KEEP);
        show = 1'b0;
        if (it.cmd == CMD_RECORD) begin
            if (it.op_class >= NUM_CLASSES) begin
                r.status = STAT_BAD_CLASS;
            end else begin
                cls_count_m[it.op_class] = sat_inc32(cls_count_m[it.op_class]);
                cls_total_m[it.op_class] = sat_add48(cls_total_m[it.op_class], it.duration);
                if (it.duration > cls_max_m[it.op_class])
                    cls_max_m[it.op_class] = it.duration;
                measured_m = sat_add48(measured_m, it.duration);
                if (it.duration >= thresh_m) begin
                    slow_m = sat_inc32(slow_m);
                    pos = 0;
                    while (pos < kept_n_m && kept_dur_m[pos] >= it.duration)
                        pos++;
                    if (pos < KEEP) begin
                        i = (kept_n_m < KEEP) ? kept_n_m : KEEP - 1;
                        while (i > pos) begin
                            kept_dur_m[i] = kept_dur_m[i-1];
                            kept_tag_m[i] = kept_tag_m[i-1];
                            i--;
                        end
                        kept_dur_m[pos] = it.duration;
                        kept_tag_m[pos] = {it.op_class, it.conn_state, it.client_id};
                        if (kept_n_m < KEEP)
                            kept_n_m++;
                        r.rank_taken = 7'(pos);
                    end
                end
                show = 1'b1;
            end
        end else if (it.cmd == CMD_READ_CLASS) begin
            if (it.op_class >= NUM_CLASSES)
                r.status = STAT_BAD_CLASS;
            else
                show = 1'b1;
        end else if (it.cmd == CMD_READ_ENTRY) begin
            if (it.entry_index >= kept_n_m) begin
                r.status = STAT_NO_ENTRY;
            end else begin
                r.entry_class    = kept_tag_m[it.entry_index][42:40];
                r.entry_state    = kept_tag_m[it.entry_index][39:32];
                r.entry_client   = kept_tag_m[it.entry_index][31:0];
                r.entry_duration = kept_dur_m[it.entry_index];
            end
        end else begin
            clear_stats();
        end
        if (show) begin
            r.class_count = cls_count_m[it.op_class];
            r.class_total = cls_total_m[it.op_class];
            r.class_max   = cls_max_m[it.op_class];
        end
        r.slow_total     = slow_m;
        r.kept_count     = 7'(kept_n_m);
        r.measured_total = measured_m;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_item(input logic [1:0] cmd, input logic [2:0] cls,
                                       input logic [31:0] dur, input logic [5:0] idx);
        event_item_t it;
        it.cmd         = cmd;
        it.op_class    = cls;
        it.conn_state  = 8'($urandom);
        it.client_id   = $urandom;
        it.duration    = dur;
        it.entry_index = idx;
        event_queue.push_back(it);
        queued_n++;
    endfunction

    function automatic void queue_random_item();
        logic [1:0]  cmd;
        logic [2:0]  cls;
        logic [31:0] dur;
        logic [5:0]  idx;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 62)
            cmd = CMD_RECORD;
        else if (r < 75)
            cmd = CMD_READ_CLASS;
        else if (r < 97)
            cmd = CMD_READ_ENTRY;
        else
            cmd = CMD_CLEAR;
        cls = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, NUM_CLASSES - 1))
                                           : 3'($urandom_range(NUM_CLASSES, 7));
        idx = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, KEEP)) : 6'($urandom);
        r = $urandom_range(0, 99);
        if (r < 30)
            dur = gen_thresh + 32'($urandom_range(0, 6)) - 32'd3;
        else if (r < 50 && dur_pool.size() > 0)
            dur = dur_pool[$urandom_range(0, dur_pool.size() - 1)];
        else if (r < 70)
            dur = $urandom;
        else if (r < 85)
            dur = $urandom_range(0, 1000);
        else
            dur = 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
        if (cmd == CMD_RECORD) begin
            dur_pool.push_back(dur);
            if (dur_pool.size() > 16)
                void'(dur_pool.pop_front());
        end
        queue_item(cmd, cls, dur, idx);
    endfunction

    task automatic check_field(input string nm, input logic [47:0] e, input logic [47:0] a);
        if (e !== a) begin
            err_n++;
            if (err_n <= 10)
                $display("result %0d %s mismatch: expected %0h, got %0h", results_n, nm, e, a);
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (!(accepted_n == queued_n && pending_results.size() == 0));
    endtask

    task automatic write_threshold(input logic [31:0] v);
        @(negedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] thr, input int n);
        wait_idle();
        write_threshold(thr);
        gen_thresh = thr;
        for (int k = 0; k < n; k++)
            queue_random_item();
    endtask

    // driver: hold until taken, then gap, then offer the next item
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_took) begin
        end else if (tx_gap > 0) begin
            tx_gap = tx_gap - 1;
            s_tvalid <= 1'b0;
        end else if (event_queue.size() > 0) begin
            tx_item = event_queue.pop_front();
            s_tdata  <= {7'd0, tx_item.entry_index, tx_item.duration, tx_item.client_id,
                         tx_item.conn_state, tx_item.op_class};
            s_tuser  <= tx_item.cmd;
            s_tvalid <= 1'b1;
            tx_gap = tx_burst ? 0 : pick_gap();
            if ($urandom_range(0, 49) == 0)
                tx_burst = !tx_burst;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!held_off && results_n >= 120) begin
            held_off = 1'b1;
            rx_hold = 400;
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!rx_burst && $urandom_range(0, 3) == 0)
                rx_wait = pick_gap();
            if ($urandom_range(0, 63) == 0)
                rx_burst = !rx_burst;
        end
    end

    // monitor: predict on input items, compare on result items
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
                thresh_m = cfg_data;
            if (s_tvalid && s_tready) begin
                seen_item.cmd         = s_tuser;
                seen_item.op_class    = s_tdata[2:0];
                seen_item.conn_state  = s_tdata[10:3];
                seen_item.client_id   = s_tdata[42:11];
                seen_item.duration    = s_tdata[74:43];
                seen_item.entry_index = s_tdata[80:75];
                pending_results.push_back(apply_command(seen_item));
                accepted_n++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    err_n++;
                    if (err_n <= 10)
                        $display("unexpected result item: status %0h data %0h", m_tuser, m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    got.status         = m_tuser;
                    got.class_count    = m_tdata[31:0];
                    got.class_total    = m_tdata[79:32];
                    got.class_max      = m_tdata[111:80];
                    got.slow_total     = m_tdata[143:112];
                    got.kept_count     = m_tdata[150:144];
                    got.measured_total = m_tdata[198:151];
                    got.entry_class    = m_tdata[201:199];
                    got.entry_state    = m_tdata[209:202];
                    got.entry_client   = m_tdata[241:210];
                    got.entry_duration = m_tdata[273:242];
                    got.rank_taken     = m_tdata[280:274];
                    check_field("status", want.status, got.status);
                    check_field("class_count", want.class_count, got.class_count);
                    check_field("class_total", want.class_total, got.class_total);
                    check_field("class_max", want.class_max, got.class_max);
                    check_field("slow_total", want.slow_total, got.slow_total);
                    check_field("kept_count", want.kept_count, got.kept_count);
                    check_field("measured_total", want.measured_total, got.measured_total);
                    check_field("entry_class", want.entry_class, got.entry_class);
                    check_field("entry_state", want.entry_state, got.entry_state);
                    check_field("entry_client", want.entry_client, got.entry_client);
                    check_field("entry_duration", want.entry_duration, got.entry_duration);
                    check_field("rank_taken", want.rank_taken, got.rank_taken);
                end
                results_n++;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        thresh_m   = THRESHOLD_RESET;
        gen_thresh = THRESHOLD_RESET;
        clear_stats();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        queue_item(CMD_READ_CLASS, 3'd0, $urandom, 6'($urandom));
        queue_item(CMD_READ_ENTRY, 3'($urandom), $urandom, 6'd0);
        queue_item(CMD_RECORD, 3'd0, 32'd0, 6'($urandom));
        queue_item(CMD_RECORD, 3'd1, THRESHOLD_RESET - 32'd1, 6'($urandom));
        queue_item(CMD_RECORD, 3'd2, THRESHOLD_RESET, 6'($urandom));
        queue_item(CMD_RECORD, 3'd3, 32'hFFFF_FFFF, 6'($urandom));
        queue_item(CMD_RECORD, 3'd5, THRESHOLD_RESET, 6'($urandom));
        queue_item(CMD_RECORD, 3'd6, 32'hFFFF_FFFF, 6'($urandom));
        queue_item(CMD_READ_CLASS, 3'd7, $urandom, 6'($urandom));
        queue_item(CMD_READ_CLASS, 3'd3, $urandom, 6'($urandom));
        queue_item(CMD_READ_ENTRY, 3'($urandom), $urandom, 6'd2);
        queue_item(CMD_READ_ENTRY, 3'($urandom), $urandom, 6'd63);
        // fill the list, then push past its end
        for (int k = 0; k < 5; k++)
            queue_item(CMD_RECORD, 3'd4, 32'd200000, 6'($urandom));
        queue_item(CMD_RECORD, 3'd0, THRESHOLD_RESET, 6'($urandom));
        queue_item(CMD_RECORD, 3'd1, 32'd150000, 6'($urandom));
        queue_item(CMD_READ_ENTRY, 3'($urandom), $urandom, 6'(KEEP - 1));
        queue_item(CMD_READ_ENTRY, 3'($urandom), $urandom, 6'd0);
        queue_item(CMD_READ_CLASS, 3'd4, $urandom, 6'($urandom));
        queue_item(CMD_CLEAR, 3'($urandom), $urandom, 6'($urandom));
        queue_item(CMD_READ_ENTRY, 3'($urandom), $urandom, 6'd0);
        queue_item(CMD_READ_CLASS, 3'd3, $urandom, 6'($urandom));

        run_phase(THRESHOLD_RESET, 180);
        run_phase(32'd0, 160);
        run_phase(32'hFFFF_FFFF, 120);
        run_phase($urandom, 120);
        run_phase(32'd50000, 150);
        run_phase(THRESHOLD_RESET, 120);

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (err_n == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
